// ----- hdl/btc_pkg.sv -----
package btc_pkg;

  localparam int IdWidth     = 40;
  localparam int StatusWidth = 3;
  localparam int LimitWidth  = 5;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_CHECKIN  = 2'd1,
    ACT_QUERY    = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [StatusWidth-1:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_UNKNOWN = 3'd2,
    STS_IN      = 3'd3,
    STS_REG     = 3'd4
  } status_t;

  // search token walking down the cell row
  typedef struct packed {
    logic               valid;
    logic               is_checkin;
    logic [IdWidth-1:0] key;
    logic [IdWidth-1:0] swap;
    logic               found;
    logic               found_in;
  } token_t;

endpackage

// ----- hdl/btc_cell.sv -----
module btc_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btc_pkg::token_t        tok_i,
  output btc_pkg::token_t        tok_o,
  input  logic [CW-1:0]          reg_cnt,
  input  logic [CW-1:0]          cin_cnt,
  input  logic                   wr_sel,
  input  logic [btc_pkg::IdWidth-1:0] wr_data
);
  import btc_pkg::*;

  localparam logic [CW-1:0] HERE = CW'(IDX);

  logic [IdWidth-1:0] entry_r;
  logic [IdWidth-1:0] entry_nxt;
  logic [IdWidth-1:0] swap_eff;
  token_t             tok_r;
  token_t             tok_nxt;
  logic               hit;
  logic               below_reg;
  logic               below_cin;
  logic               at_cin;

  always_comb begin
    below_reg = HERE < reg_cnt;
    below_cin = HERE < cin_cnt;
    at_cin    = HERE == cin_cnt;
    // the boundary entry is picked up as the token passes it
    swap_eff  = (tok_i.is_checkin && at_cin) ? entry_r : tok_i.swap;
    hit = tok_i.valid && !tok_i.found && below_reg && (entry_r == tok_i.key) &&
          (!tok_i.is_checkin || !below_cin);
    tok_nxt      = tok_i;
    tok_nxt.swap = swap_eff;
    if (hit) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.found_in = below_cin;
    end
    entry_nxt = entry_r;
    if (wr_sel) begin
      entry_nxt = wr_data;
    end else if (hit && tok_i.is_checkin) begin
      entry_nxt = swap_eff;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- hdl/badge_table_checkin_core.sv -----
// Badge check-in table built as a row of TABLE_DEPTH cells, one stored badge
// id per cell. Register and clear finish in the cycle of the transfer, and the
// result is offered on the next cycle. Check-in and query send a search token
// down the row, one cell per cycle, and the result is registered when the
// token leaves the last cell. A check-in that matches swaps the entry with the
// one at the checked-in boundary: the token carries the boundary entry into
// the matching cell and the badge id is written back at the boundary when the
// scan ends. One operation is in progress at a time; a new transfer is taken
// once the block is idle and the result register is free or being emptied.
// The working limit may be written at any idle moment and resets to 16.
module badge_table_checkin_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [btc_pkg::IdWidth-1:0]     in_badge_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btc_pkg::StatusWidth-1:0] out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btc_pkg::LimitWidth-1:0]  cfg_data
);
  import btc_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > LimitWidth) ? CW : LimitWidth;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          reg_cnt_r, reg_cnt_nxt;
  logic [CW-1:0]          cin_cnt_r, cin_cnt_nxt;
  logic [LimitWidth-1:0]  limit_r, limit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [StatusWidth-1:0] out_status_r, out_status_nxt;
  token_t                 launch_r, launch_nxt;
  token_t                 tok [TABLE_DEPTH+1];
  logic                   wr_en;
  logic [CW-1:0]          wr_idx;
  logic [IdWidth-1:0]     wr_data;
  logic [TABLE_DEPTH-1:0] wr_sel;
  logic                   in_xfer;
  logic                   at_limit;
  token_t                 done_tok;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign at_limit  = LW'(cin_cnt_r) >= LW'(limit_r);
  assign tok[0]    = launch_r;
  assign done_tok  = tok[TABLE_DEPTH];

  always_comb begin
    state_nxt      = state_r;
    reg_cnt_nxt    = reg_cnt_r;
    cin_cnt_nxt    = cin_cnt_r;
    limit_nxt      = (cfg_valid && cfg_ready) ? cfg_data : limit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    launch_nxt            = launch_r;
    launch_nxt.valid      = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = reg_cnt_r;
    wr_data = in_badge_id;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          launch_nxt.is_checkin = 1'b0;
          launch_nxt.key        = in_badge_id;
          launch_nxt.swap       = in_badge_id;
          launch_nxt.found      = 1'b0;
          launch_nxt.found_in   = 1'b0;
          case (in_action)
            ACT_REGISTER: begin
              out_valid_nxt = 1'b1;
              if (reg_cnt_r == DEPTH_CNT) begin
                out_status_nxt = STS_FULL;
              end else begin
                wr_en          = 1'b1;
                reg_cnt_nxt    = reg_cnt_r + 1'b1;
                out_status_nxt = STS_OK;
              end
            end
            ACT_CHECKIN: begin
              if (at_limit) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_FULL;
              end else begin
                launch_nxt.valid      = 1'b1;
                launch_nxt.is_checkin = 1'b1;
                state_nxt             = ST_SCAN;
              end
            end
            ACT_QUERY: begin
              launch_nxt.valid = 1'b1;
              state_nxt        = ST_SCAN;
            end
            default: begin
              reg_cnt_nxt    = '0;
              cin_cnt_nxt    = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_OK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (done_tok.valid) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!done_tok.found) begin
            out_status_nxt = STS_UNKNOWN;
          end else if (done_tok.is_checkin) begin
            // matched id lands on the checked-in boundary
            wr_en          = 1'b1;
            wr_idx         = cin_cnt_r;
            wr_data        = done_tok.key;
            cin_cnt_nxt    = cin_cnt_r + 1'b1;
            out_status_nxt = STS_OK;
          end else begin
            out_status_nxt = done_tok.found_in ? STS_IN : STS_REG;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wr_sel[i] = wr_en && (wr_idx == CW'(i));
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    btc_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .reg_cnt (reg_cnt_r),
      .cin_cnt (cin_cnt_r),
      .wr_sel  (wr_sel[g]),
      .wr_data (wr_data)
    );
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      reg_cnt_r      <= '0;
      cin_cnt_r      <= '0;
      limit_r        <= LimitWidth'(16);
      out_valid_r    <= 1'b0;
      launch_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      reg_cnt_r   <= reg_cnt_nxt;
      cin_cnt_r   <= cin_cnt_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      launch_r    <= launch_nxt;
    end
  end

endmodule

// ----- hdl/btc_checker.sv -----
module btc_props (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      in_action,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [btc_pkg::StatusWidth-1:0] out_status
);
  import btc_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STS_REG)
    else $error("status code out of range");

  // a new transfer only when the result slot is free or draining
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while result blocked");

  a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_CLEAR |=> out_valid && out_status == STS_OK)
    else $error("clear did not report ok");

endmodule

bind badge_table_checkin_core btc_props u_btc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_action  (in_action),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status)
);
